// ===== src/vslc_pkg.sv =====
// Package for the video sync line capture block.
// Holds line geometry constants, phase codes, register indexes and the result type.
// No dependencies.
package vslc_pkg;

    // Visible window of one field
    localparam int VISIBLE_WIDTH  = 256;
    localparam int VISIBLE_HEIGHT = 240;

    // Line phase codes
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_SYNC   = 2'd1;
    localparam logic [1:0] PH_PORCH  = 2'd2;
    localparam logic [1:0] PH_ACTIVE = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_SAMPLES_PER_PCLK  = 2'd0;
    localparam logic [1:0] REG_BACK_PORCH_PIXELS = 2'd1;
    localparam logic [1:0] REG_PIXELS_PER_SCAN   = 2'd2;
    localparam logic [1:0] REG_SCANS_PER_FIELD   = 2'd3;

    // Reset values of the configuration registers
    localparam logic [3:0] RST_SAMPLES_PER_PCLK  = 4'd1;
    localparam logic [7:0] RST_BACK_PORCH_PIXELS = 8'd40;
    localparam logic [8:0] RST_PIXELS_PER_SCAN   = 9'd341;
    localparam logic [8:0] RST_SCANS_PER_FIELD   = 9'd262;

    // Sampling pitch limits
    localparam logic [3:0] PITCH_MIN = 4'd1;
    localparam logic [3:0] PITCH_MAX = 4'd8;

    // One result item
    typedef struct packed {
        logic       pixel_valid;
        logic [7:0] row;
        logic [7:0] column;
        logic [8:0] pixel_value;
        logic       field_end;
    } t_result;

endpackage

// ===== src/video_sync_line_capture.sv =====
// Top level of the video sync line capture block.
// A result is registered and appears on the master side in the cycle after its sample is accepted.
// Throughput: one sample per cycle unless stalled; line state and counters are one registered pass.
// The output register is one deep: while a result waits untaken the input is held off.
// Reset (synchronous, active low): phase idle, all counters zero, output empty,
// configuration registers back to their defaults.
// Depends on vslc_pkg.
module video_sync_line_capture (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [8:0]  i_cfg_wdata,
    // sample stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [8:0] raw_pixel, [15:9] zero
    input  logic        s_axis_tuser,   // [0] sync_level
    // pixel stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] row, [15:8] column, [24:16] pixel_value, [31:25] zero
    output logic        m_axis_tuser,   // [0] pixel_valid
    output logic        m_axis_tlast    // field_end
);

    // Configuration registers
    logic [3:0] r_samples_per_pclk;
    logic [7:0] r_back_porch_pixels;
    logic [8:0] r_pixels_per_scan;
    logic [8:0] r_scans_per_field;

    // Line state
    logic [1:0] r_phase,        n_phase;
    logic [9:0] r_sample_count, n_sample_count;
    logic [2:0] r_timeout_sub,  n_timeout_sub;
    logic [2:0] r_pitch_count,  n_pitch_count;
    logic [8:0] r_pixel_count,  n_pixel_count;
    logic [8:0] r_row_count,    n_row_count;

    // Output register
    logic                 r_out_valid;
    vslc_pkg::t_result    r_out;
    vslc_pkg::t_result    n_out;
    logic                 n_out_valid;

    logic                 s_fire;
    logic [3:0]           spp;
    logic                 sync;

    // Accept a sample whenever the output register is free or being drained
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign sync          = s_axis_tuser;

    // Clamp the sampling pitch into 1..8
    always_comb begin
        if (r_samples_per_pclk == 4'd0) begin
            spp = vslc_pkg::PITCH_MIN;
        end else if (r_samples_per_pclk > vslc_pkg::PITCH_MAX) begin
            spp = vslc_pkg::PITCH_MAX;
        end else begin
            spp = r_samples_per_pclk;
        end
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samples_per_pclk  <= vslc_pkg::RST_SAMPLES_PER_PCLK;
            r_back_porch_pixels <= vslc_pkg::RST_BACK_PORCH_PIXELS;
            r_pixels_per_scan   <= vslc_pkg::RST_PIXELS_PER_SCAN;
            r_scans_per_field   <= vslc_pkg::RST_SCANS_PER_FIELD;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                vslc_pkg::REG_SAMPLES_PER_PCLK:  r_samples_per_pclk  <= i_cfg_wdata[3:0];
                vslc_pkg::REG_BACK_PORCH_PIXELS: r_back_porch_pixels <= i_cfg_wdata[7:0];
                vslc_pkg::REG_PIXELS_PER_SCAN:   r_pixels_per_scan   <= i_cfg_wdata;
                vslc_pkg::REG_SCANS_PER_FIELD:   r_scans_per_field   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Advance the line state for one sample and form its result
    always_comb begin
        logic [1:0] ph;
        logic [9:0] sc;
        logic [3:0] ts;
        logic [3:0] pc;
        logic [8:0] px;
        logic [8:0] rw;
        logic       go;
        logic       vis;
        logic       fend;
        logic       res;

        ph   = r_phase;
        sc   = r_sample_count;
        ts   = {1'b0, r_timeout_sub};
        pc   = {1'b0, r_pitch_count};
        px   = r_pixel_count;
        rw   = r_row_count;
        go   = s_fire;
        vis  = 1'b0;
        fend = 1'b0;
        res  = 1'b0;
        n_out = '0;

        // Start a line on sync high
        if (go && ph == vslc_pkg::PH_IDLE) begin
            if (!sync) begin
                go = 1'b0;
            end else begin
                ph = vslc_pkg::PH_SYNC;
                sc = '0;
                ts = '0;
            end
        end

        if (go) begin
            // Leave sync when it drops
            if (ph == vslc_pkg::PH_SYNC && !sync) begin
                ph = vslc_pkg::PH_PORCH;
                pc = '0;
                px = '0;
            end

            // Skip the back porch
            if (ph == vslc_pkg::PH_PORCH) begin
                if (px >= {1'b0, r_back_porch_pixels}) begin
                    ph = vslc_pkg::PH_ACTIVE;
                    px = '0;
                    pc = '0;
                end else begin
                    pc = pc + 4'd1;
                    if (pc >= spp) begin
                        pc = '0;
                        px = px + 9'd1;
                    end
                end
            end

            // Take one pixel each pitch
            if (ph == vslc_pkg::PH_ACTIVE) begin
                if (pc == 4'd0) begin
                    vis = rw < 9'(vslc_pkg::VISIBLE_HEIGHT);
                    n_out.row         = vis ? rw[7:0] : 8'd0;
                    n_out.column      = vis ? px[7:0] : 8'd0;
                    n_out.pixel_value = vis ? s_axis_tdata[8:0] : 9'd0;
                    px = px + 9'd1;
                    if (px >= 9'(vslc_pkg::VISIBLE_WIDTH)) begin
                        rw = rw + 9'd1;
                        if (rw >= r_scans_per_field) begin
                            rw   = '0;
                            fend = 1'b1;
                        end
                        ph = vslc_pkg::PH_IDLE;
                    end
                    res = vis || fend;
                end
                if (ph == vslc_pkg::PH_ACTIVE) begin
                    pc = pc + 4'd1;
                    if (pc >= spp) begin
                        pc = '0;
                    end
                end
            end

            // Abandon a line that runs past twice the scan length
            if (ph != vslc_pkg::PH_IDLE) begin
                ts = ts + 4'd1;
                if (ts >= spp) begin
                    ts = '0;
                    sc = sc + 10'd1;
                end
                if (sc >= {r_pixels_per_scan, 1'b0}) begin
                    ph = vslc_pkg::PH_IDLE;
                    sc = '0;
                    ts = '0;
                end
            end
        end

        n_out.pixel_valid = vis;
        n_out.field_end   = fend;
        n_out_valid       = s_fire && res;

        n_phase        = ph;
        n_sample_count = sc;
        n_timeout_sub  = ts[2:0];
        n_pitch_count  = pc[2:0];
        n_pixel_count  = px;
        n_row_count    = rw;
    end

    // Hold line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= vslc_pkg::PH_IDLE;
            r_sample_count <= '0;
            r_timeout_sub  <= '0;
            r_pitch_count  <= '0;
            r_pixel_count  <= '0;
            r_row_count    <= '0;
        end else begin
            r_phase        <= n_phase;
            r_sample_count <= n_sample_count;
            r_timeout_sub  <= n_timeout_sub;
            r_pitch_count  <= n_pitch_count;
            r_pixel_count  <= n_pixel_count;
            r_row_count    <= n_row_count;
        end
    end

    // Load the output register when it is free or draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && n_out_valid) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.pixel_value, r_out.column, r_out.row};
    assign m_axis_tuser  = r_out.pixel_valid;
    assign m_axis_tlast  = r_out.field_end;

endmodule

// ===== src/vslc_checker.sv =====
// Port-level checker for the video sync line capture block, with its bind.
// Watches the output stream only; no dependencies beyond the top level's ports.
module vslc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // Hold a stalled transaction
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output transaction changed while stalled");

    // A transaction without a pixel only exists to close a field
    a_empty_is_field_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 32'd0)
        else $error("empty transaction without field end or with data");

    // Visible rows stay below the visible height
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7:0] < 8'd240)
        else $error("pixel row outside the visible window");

    // Drop output after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind video_sync_line_capture vslc_checker u_vslc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
